@@ sv/lru_session_table_macros.svh @@
// Assertion macros for the LRU session table.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef LRU_SESSION_TABLE_MACROS_SVH
`define LRU_SESSION_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define LST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define LST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LST_ASSERT_SAME(label, ante, cons, msg)

`define LST_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ sv/lst_pkg.sv @@
// Shared types and constants for the LRU session table.
// No dependencies.
package lst_pkg;

  localparam int KEY_W   = 64;
  localparam int STAMP_W = 64;
  localparam int SLOT_W  = 6;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [1:0]         status_t;

  localparam status_t ST_HIT      = 2'd0;
  localparam status_t ST_CREATED  = 2'd1;
  localparam status_t ST_EVICTED  = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic   valid;
    key_t   key;
    stamp_t stamp;
  } entry_t;

endpackage

@@ sv/lst_if.sv @@
// Request and result channel interfaces for the LRU session table.
// Depends on lst_pkg.
interface lst_in_if import lst_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  key_t  session_key;

  modport source (output valid, output req_type, output session_key, input ready);
  modport sink   (input valid, input req_type, input session_key, output ready);
endinterface

interface lst_out_if import lst_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot;
  key_t    evicted_key;

  modport source (output valid, output status, output slot, output evicted_key, input ready);
  modport sink   (input valid, input status, input slot, input evicted_key, output ready);
endinterface

@@ sv/lst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lru_session_table.sv @@
// Channel  | Dir | Payload                        | Handshake
// in_ch    | in  | req_type, session_key          | valid/ready
// out_ch   | out | status, slot, evicted_key      | valid/ready
//
// Each request runs a scan from accept to the result register: one slot is read per cycle
// through the single RAM read port and checked by one shared key compare and one shared
// stamp compare, then S_WRITE writes the chosen slot unless a find-only request misses.
// After reset a clearing pass invalidates every slot; in_ch is not ready.
// The result register frees in_ch: a new request is taken while an old result still waits.
// Depends on lst_pkg, lst_if, lst_ram and lru_session_table_macros.svh.
`include "lru_session_table_macros.svh"

module lru_session_table import lst_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  lst_in_if.sink    in_ch,
  lst_out_if.source out_ch
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W = $bits(entry_t);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             find_only_r, find_only_nxt;
  key_t             key_r, key_nxt;
  logic             hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             cold_found_r, cold_found_nxt;
  logic [IDX_W-1:0] cold_idx_r, cold_idx_nxt;
  stamp_t           cold_stamp_r, cold_stamp_nxt;
  key_t             cold_key_r, cold_key_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  stamp_t           use_r, use_nxt;
  status_t          res_status_r, res_status_nxt;
  slot_t            res_slot_r, res_slot_nxt;
  key_t             res_evict_r, res_evict_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  slot_t            out_slot_r, out_slot_nxt;
  key_t             out_evict_r, out_evict_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           rd_entry;
  stamp_t           stamp_new;
  logic             in_acc;
  logic             out_free;

  lst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry     = entry_t'(ram_rdata);
  assign stamp_new    = use_r + STAMP_W'(1);
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.evicted_key = out_evict_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    find_only_nxt  = find_only_r;
    key_nxt        = key_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    cold_found_nxt = cold_found_r;
    cold_idx_nxt   = cold_idx_r;
    cold_stamp_nxt = cold_stamp_r;
    cold_key_nxt   = cold_key_r;
    use_nxt        = use_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_evict_nxt  = res_evict_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_evict_nxt  = out_evict_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[IDX_W-1:0];
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = cnt_r[IDX_W-1:0];

    // check the slot returned by the previous read
    if (rd_vld_r) begin
      if (rd_entry.valid && rd_entry.key == key_r && !hit_found_r) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = rd_idx_r;
      end
      if (!rd_entry.valid && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = rd_idx_r;
      end
      if (rd_entry.valid && (!cold_found_r || rd_entry.stamp < cold_stamp_r)) begin
        cold_found_nxt = 1'b1;
        cold_idx_nxt   = rd_idx_r;
        cold_stamp_nxt = rd_entry.stamp;
        cold_key_nxt   = rd_entry.key;
      end
    end

    unique case (state_r)
      S_CLR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          find_only_nxt  = in_ch.req_type;
          key_nxt        = in_ch.session_key;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          cold_found_nxt = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != CNT_W'(NUM_SLOTS)) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt    = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_wdata.valid = 1'b1;
        ram_wdata.key   = key_r;
        ram_wdata.stamp = stamp_new;
        res_evict_nxt   = '0;
        priority if (hit_found_r) begin
          ram_we         = 1'b1;
          ram_waddr      = hit_idx_r;
          res_status_nxt = ST_HIT;
          res_slot_nxt   = SLOT_W'(hit_idx_r);
        end else if (find_only_r) begin
          res_status_nxt = ST_NOTFOUND;
          res_slot_nxt   = '0;
        end else if (free_found_r) begin
          ram_we         = 1'b1;
          ram_waddr      = free_idx_r;
          res_status_nxt = ST_CREATED;
          res_slot_nxt   = SLOT_W'(free_idx_r);
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = cold_idx_r;
          res_status_nxt = ST_EVICTED;
          res_slot_nxt   = SLOT_W'(cold_idx_r);
          res_evict_nxt  = cold_key_r;
        end
        if (ram_we) begin
          use_nxt = stamp_new;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_evict_nxt  = res_evict_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      cold_found_r <= 1'b0;
      use_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      cold_found_r <= cold_found_nxt;
      use_r        <= use_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    find_only_r  <= find_only_nxt;
    key_r        <= key_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    cold_idx_r   <= cold_idx_nxt;
    cold_stamp_r <= cold_stamp_nxt;
    cold_key_r   <= cold_key_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_evict_r  <= res_evict_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_evict_r  <= out_evict_nxt;
  end

  `LST_ASSERT_NEXT(a_acc_scan, in_acc, state_r == S_SCAN, "accepted word did not start a scan")
  `LST_ASSERT_SAME(a_we_state, ram_we, state_r == S_CLR || state_r == S_WRITE, "table write outside clear or update")
  `LST_ASSERT_NEXT(a_use_step, 1'b1, use_r == $past(use_r) || use_r == $past(use_r) + STAMP_W'(1), "use counter jumped")
  `LST_ASSERT_SAME(a_free_pick, state_r == S_WRITE && !hit_found_r && !find_only_r && free_found_r, ram_we && ram_waddr == free_idx_r, "create did not take the free slot")

endmodule
